@@ rtl/bcd_pkg.sv @@
// Shared types, constants and divide helpers for the BC1..BC5 texel decoder.
// No dependencies; every other file of the block imports this package.
package bcd_pkg;

    // Block format codes held in the format register
    localparam logic [2:0] FMT_BC1 = 3'd0;
    localparam logic [2:0] FMT_BC2 = 3'd1;
    localparam logic [2:0] FMT_BC3 = 3'd2;
    localparam logic [2:0] FMT_BC4 = 3'd3;
    localparam logic [2:0] FMT_BC5 = 3'd4;

    // Datapath widths of the rounding divider
    localparam int X_W       = 17;   // dividend 2*K*N + D
    localparam int Y_W       = 9;    // divisor 2*D
    localparam int Q_W       = 9;    // quotient estimate
    localparam int RCP_SHIFT = 24;   // reciprocal scale 2^RCP_SHIFT

    // Reciprocals floor(2^RCP_SHIFT / (2*D)) for every divisor in use
    localparam int unsigned RCP_1   = (1 << RCP_SHIFT) / 2;
    localparam int unsigned RCP_5   = (1 << RCP_SHIFT) / 10;
    localparam int unsigned RCP_7   = (1 << RCP_SHIFT) / 14;
    localparam int unsigned RCP_31  = (1 << RCP_SHIFT) / 62;
    localparam int unsigned RCP_62  = (1 << RCP_SHIFT) / 124;
    localparam int unsigned RCP_93  = (1 << RCP_SHIFT) / 186;
    localparam int unsigned RCP_63  = (1 << RCP_SHIFT) / 126;
    localparam int unsigned RCP_126 = (1 << RCP_SHIFT) / 252;
    localparam int unsigned RCP_189 = (1 << RCP_SHIFT) / 378;

    // Divisor D of a rounded quotient round(N'/D); DV_1 passes a value through
    typedef enum logic [3:0] {
        DV_1, DV_5, DV_7, DV_31, DV_62, DV_93, DV_63, DV_126, DV_189
    } t_div;

    // One alpha-style half: two endpoints and the selected 3-bit index
    typedef struct packed {
        logic [7:0] a0;
        logic [7:0] a1;
        logic [2:0] idx;
    } t_ahalf;

    // Fields pulled out of the block for one texel
    typedef struct packed {
        logic [2:0]  fmt;
        logic [15:0] c0;
        logic [15:0] c1;
        logic [1:0]  cidx;
        logic        three;
        t_ahalf      alo;
        t_ahalf      ahi;
        logic [3:0]  nib;
    } t_s1;

    // One output channel ready for the divider: value = floor(x / (2*D))
    typedef struct packed {
        logic [X_W-1:0] x;
        t_div           dv;
    } t_lane;

    // Register enables of the four pipeline stages
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } t_stage_en;

    // Divisor 2*D for a divisor code
    function automatic logic [Y_W-1:0] div_den(input t_div dv);
        logic [Y_W-1:0] y;
        case (dv)
            DV_1:    y = 9'd2;
            DV_5:    y = 9'd10;
            DV_7:    y = 9'd14;
            DV_31:   y = 9'd62;
            DV_62:   y = 9'd124;
            DV_93:   y = 9'd186;
            DV_63:   y = 9'd126;
            DV_126:  y = 9'd252;
            DV_189:  y = 9'd378;
            default: y = 9'd2;
        endcase
        return y;
    endfunction

    // Reciprocal of 2*D for a divisor code
    function automatic logic [RCP_SHIFT-1:0] div_rcp(input t_div dv);
        logic [RCP_SHIFT-1:0] r;
        case (dv)
            DV_1:    r = RCP_SHIFT'(RCP_1);
            DV_5:    r = RCP_SHIFT'(RCP_5);
            DV_7:    r = RCP_SHIFT'(RCP_7);
            DV_31:   r = RCP_SHIFT'(RCP_31);
            DV_62:   r = RCP_SHIFT'(RCP_62);
            DV_93:   r = RCP_SHIFT'(RCP_93);
            DV_63:   r = RCP_SHIFT'(RCP_63);
            DV_126:  r = RCP_SHIFT'(RCP_126);
            DV_189:  r = RCP_SHIFT'(RCP_189);
            default: r = RCP_SHIFT'(RCP_1);
        endcase
        return r;
    endfunction

endpackage

@@ rtl/bcd_extract.sv @@
// Stage 1: pick the color half by format and select the texel's color and alpha indices.
// Depends on bcd_pkg.
module bcd_extract
    import bcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [2:0]  i_fmt,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    input  logic [3:0]  i_texel,
    output t_s1         o_s1
);

    logic [63:0] color_half;
    logic [31:0] cidx_vec;
    logic [47:0] aidx_lo_vec;
    logic [47:0] aidx_hi_vec;
    logic [63:0] nib_vec;
    logic [5:0]  a_shift;
    t_s1         n_s1;
    t_s1         r_s1;

    // BC1 keeps its color in the low half, BC2 and BC3 in the high half
    assign color_half = (i_fmt == FMT_BC1) ? i_block_low : i_block_high;
    assign a_shift    = ({2'b00, i_texel} << 1) + {2'b00, i_texel};

    assign cidx_vec    = color_half[63:32] >> {i_texel, 1'b0};
    assign aidx_lo_vec = i_block_low[63:16] >> a_shift;
    assign aidx_hi_vec = i_block_high[63:16] >> a_shift;
    assign nib_vec     = i_block_low >> {i_texel, 2'b00};

    always_comb begin
        n_s1.fmt     = i_fmt;
        n_s1.c0      = color_half[15:0];
        n_s1.c1      = color_half[31:16];
        n_s1.cidx    = cidx_vec[1:0];
        // three-color mode exists only for BC1
        n_s1.three   = (i_fmt == FMT_BC1) && (color_half[15:0] <= color_half[31:16]);
        n_s1.alo.a0  = i_block_low[7:0];
        n_s1.alo.a1  = i_block_low[15:8];
        n_s1.alo.idx = aidx_lo_vec[2:0];
        n_s1.ahi.a0  = i_block_high[7:0];
        n_s1.ahi.a1  = i_block_high[15:8];
        n_s1.ahi.idx = aidx_hi_vec[2:0];
        n_s1.nib     = nib_vec[3:0];
    end

    // Hold while the next stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

@@ rtl/bcd_lane_setup.sv @@
// Stage 2: form the weighted endpoint sum and divisor of each output channel.
// Depends on bcd_pkg.
module bcd_lane_setup
    import bcd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_s1   i_s1,
    output t_lane o_red,
    output t_lane o_green,
    output t_lane o_blue,
    output t_lane o_alpha
);

    t_lane n_red;
    t_lane n_green;
    t_lane n_blue;
    t_lane n_alpha;
    t_lane r_red;
    t_lane r_green;
    t_lane r_blue;
    t_lane r_alpha;
    logic  transparent;

    // Pass a finished 8-bit value through the divider unchanged
    function automatic t_lane direct_lane(input logic [7:0] v);
        t_lane l;
        l.x  = {8'b0, v, 1'b1};
        l.dv = DV_1;
        return l;
    endfunction

    // Color channel: x = 510*(wa*e0 + wb*e1) + D, D = den * channel max
    function automatic t_lane color_lane(input logic [5:0] e0, input logic [5:0] e1,
                                         input logic [1:0] cidx, input logic three,
                                         input logic six);
        logic [1:0] wa;
        logic [1:0] wb;
        logic [7:0] n;
        logic [7:0] d;
        t_lane      l;
        case (cidx)
            2'd0: begin
                wa = 2'd1; wb = 2'd0;
                l.dv = six ? DV_63 : DV_31;
            end
            2'd1: begin
                wa = 2'd0; wb = 2'd1;
                l.dv = six ? DV_63 : DV_31;
            end
            2'd2: begin
                if (three) begin
                    wa = 2'd1; wb = 2'd1;
                    l.dv = six ? DV_126 : DV_62;
                end else begin
                    wa = 2'd2; wb = 2'd1;
                    l.dv = six ? DV_189 : DV_93;
                end
            end
            default: begin
                wa = 2'd1; wb = 2'd2;
                l.dv = six ? DV_189 : DV_93;
            end
        endcase
        n   = 8'(wa) * 8'(e0) + 8'(wb) * 8'(e1);
        d   = 8'(div_den(l.dv) >> 1);
        l.x = (X_W'(n) << 9) - (X_W'(n) << 1) + X_W'(d);
        return l;
    endfunction

    // Alpha-style channel: 8- or 6-entry palette from two 8-bit endpoints
    function automatic t_lane alpha_lane(input t_ahalf h);
        logic [3:0]  wa;
        logic [3:0]  wb;
        logic [10:0] n;
        t_lane       l;
        wa = 4'd0;
        wb = 4'd0;
        n  = 11'd0;
        if (h.idx == 3'd0) begin
            l = direct_lane(h.a0);
        end else if (h.idx == 3'd1) begin
            l = direct_lane(h.a1);
        end else if (h.a0 > h.a1) begin
            wa   = 4'd8 - {1'b0, h.idx};
            wb   = {1'b0, h.idx} - 4'd1;
            n    = 11'(wa) * 11'(h.a0) + 11'(wb) * 11'(h.a1);
            l.x  = (X_W'(n) << 1) + X_W'(7);
            l.dv = DV_7;
        end else if (h.idx == 3'd6) begin
            l = direct_lane(8'd0);
        end else if (h.idx == 3'd7) begin
            l = direct_lane(8'd255);
        end else begin
            wa   = 4'd6 - {1'b0, h.idx};
            wb   = {1'b0, h.idx} - 4'd1;
            n    = 11'(wa) * 11'(h.a0) + 11'(wb) * 11'(h.a1);
            l.x  = (X_W'(n) << 1) + X_W'(5);
            l.dv = DV_5;
        end
        return l;
    endfunction

    // BC1 three-color mode, last palette entry: transparent black
    assign transparent = i_s1.three && (i_s1.cidx == 2'd3);

    // Route each channel by block format
    always_comb begin
        n_red   = direct_lane(8'd0);
        n_green = direct_lane(8'd0);
        n_blue  = direct_lane(8'd0);
        n_alpha = direct_lane(8'd0);
        case (i_s1.fmt)
            FMT_BC1, FMT_BC2, FMT_BC3: begin
                n_red   = color_lane({1'b0, i_s1.c0[15:11]}, {1'b0, i_s1.c1[15:11]},
                                     i_s1.cidx, i_s1.three, 1'b0);
                n_green = color_lane(i_s1.c0[10:5], i_s1.c1[10:5],
                                     i_s1.cidx, i_s1.three, 1'b1);
                n_blue  = color_lane({1'b0, i_s1.c0[4:0]}, {1'b0, i_s1.c1[4:0]},
                                     i_s1.cidx, i_s1.three, 1'b0);
                if (i_s1.fmt == FMT_BC1) begin
                    n_alpha = direct_lane(8'd255);
                end else if (i_s1.fmt == FMT_BC2) begin
                    n_alpha = direct_lane({i_s1.nib, i_s1.nib});
                end else begin
                    n_alpha = alpha_lane(i_s1.alo);
                end
                if (transparent) begin
                    n_red   = direct_lane(8'd0);
                    n_green = direct_lane(8'd0);
                    n_blue  = direct_lane(8'd0);
                    n_alpha = direct_lane(8'd0);
                end
            end
            FMT_BC4: begin
                n_red   = alpha_lane(i_s1.alo);
                n_alpha = direct_lane(8'd255);
            end
            FMT_BC5: begin
                n_red   = alpha_lane(i_s1.alo);
                n_green = alpha_lane(i_s1.ahi);
                n_alpha = direct_lane(8'd255);
            end
            default: begin
                n_red   = direct_lane(8'd0);
            end
        endcase
    end

    // Hold while the next stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_alpha <= n_alpha;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_alpha = r_alpha;

endmodule

@@ rtl/bcd_round_div.sv @@
// Stages 3 and 4: rounded divide of one channel by a small constant set,
// reciprocal multiply then a one-step correction. Depends on bcd_pkg.
module bcd_round_div
    import bcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en3,
    input  logic       i_en4,
    input  t_lane      i_lane,
    output logic [7:0] o_value
);

    logic [X_W+RCP_SHIFT-1:0] prod;
    logic [Q_W-1:0]           n_q0;
    logic [Q_W-1:0]           r_q0;
    logic [X_W-1:0]           r_x;
    t_div                     r_dv;
    logic [Y_W-1:0]           y;
    logic [Q_W+Y_W-1:0]       qy;
    logic [Q_W+Y_W-1:0]       rem;
    logic [Q_W-1:0]           q;
    logic [7:0]               r_value;

    // Estimate: never above the true quotient, at most one below
    assign prod = (X_W+RCP_SHIFT)'(i_lane.x) * (X_W+RCP_SHIFT)'(div_rcp(i_lane.dv));
    assign n_q0 = prod[RCP_SHIFT +: Q_W];

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_q0 <= n_q0;
            r_x  <= i_lane.x;
            r_dv <= i_lane.dv;
        end
    end

    // Correct the estimate by one where the remainder reaches the divisor
    assign y   = div_den(r_dv);
    assign qy  = (Q_W+Y_W)'(r_q0) * (Q_W+Y_W)'(y);
    assign rem = (Q_W+Y_W)'(r_x) - qy;
    assign q   = r_q0 + ((rem >= (Q_W+Y_W)'(y)) ? Q_W'(1) : Q_W'(0));

    always_ff @(posedge i_clk) begin
        if (i_en4) begin
            r_value <= q[7:0];
        end
    end

    assign o_value = r_value;

endmodule

@@ rtl/bc_block_texel_decoder.sv @@
// Top level of the BC1..BC5 texel decoder: handshakes, format register, stage control.
// Depends on bcd_pkg, bcd_extract, bcd_lane_setup and bcd_round_div.
//
// Decodes one texel of a compressed 4x4 block (BC1, BC2, BC3, BC4 or BC5, chosen
// by the format register) to 8-bit RGBA. The pipeline has four register stages:
// index extraction, palette weighting, reciprocal multiply, and remainder
// correction into the output register. A transaction is accepted every cycle
// while the output side keeps up. The first stage captures the input at the
// accepting edge; the texel then passes through the second, third and fourth
// stage registers, and o_valid is the valid bit of the fourth. The four stage
// registers carry their own valid bits, so a stall on the output side backs up
// only the stages that are full. Write the format register only while no
// texel is in flight.
module bc_block_texel_decoder
    import bcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // format register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data,
    // block input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    input  logic [1:0]  i_texel_x,
    input  logic [1:0]  i_texel_y,
    // texel output
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha
);

    logic [2:0] r_block_format;
    logic       r_v1;
    logic       r_v2;
    logic       r_v3;
    logic       r_v4;
    t_stage_en  en;
    t_s1        s1;
    t_lane      lane_red;
    t_lane      lane_green;
    t_lane      lane_blue;
    t_lane      lane_alpha;

    // Format register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_format <= FMT_BC1;
        end else if (i_cfg_valid) begin
            r_block_format <= i_cfg_data;
        end
    end

    // Advance a stage when it is empty or its contents move on
    assign en.en4 = !r_v4 || i_ready;
    assign en.en3 = !r_v3 || en.en4;
    assign en.en2 = !r_v2 || en.en3;
    assign en.en1 = !r_v1 || en.en2;
    assign o_ready = en.en1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.en1) begin
                r_v1 <= i_valid;
            end
            if (en.en2) begin
                r_v2 <= r_v1;
            end
            if (en.en3) begin
                r_v3 <= r_v2;
            end
            if (en.en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Stage 1: extract
    bcd_extract u_extract (
        .i_clk        (i_clk),
        .i_en         (en.en1),
        .i_fmt        (r_block_format),
        .i_block_low  (i_block_low),
        .i_block_high (i_block_high),
        .i_texel      ({i_texel_y, i_texel_x}),
        .o_s1         (s1)
    );

    // Stage 2: palette weights
    bcd_lane_setup u_lane_setup (
        .i_clk   (i_clk),
        .i_en    (en.en2),
        .i_s1    (s1),
        .o_red   (lane_red),
        .o_green (lane_green),
        .o_blue  (lane_blue),
        .o_alpha (lane_alpha)
    );

    // Stages 3 and 4: rounded divide per channel
    bcd_round_div u_div_red (
        .i_clk   (i_clk),
        .i_en3   (en.en3),
        .i_en4   (en.en4),
        .i_lane  (lane_red),
        .o_value (o_red)
    );

    bcd_round_div u_div_green (
        .i_clk   (i_clk),
        .i_en3   (en.en3),
        .i_en4   (en.en4),
        .i_lane  (lane_green),
        .o_value (o_green)
    );

    bcd_round_div u_div_blue (
        .i_clk   (i_clk),
        .i_en3   (en.en3),
        .i_en4   (en.en4),
        .i_lane  (lane_blue),
        .o_value (o_blue)
    );

    bcd_round_div u_div_alpha (
        .i_clk   (i_clk),
        .i_en3   (en.en3),
        .i_en4   (en.en4),
        .i_lane  (lane_alpha),
        .o_value (o_alpha)
    );

endmodule

@@ bench/tb_bc_block_texel_decoder.sv @@
// Self-checking testbench for bc_block_texel_decoder: BC1..BC5 texel decode
// against a behavioral predictor, with random stalls on both handshakes.
// Depends on bcd_pkg and the decoder RTL.

import bcd_pkg::*;

typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
} texel_t;

class texel_scoreboard;
    logic [2:0]  format_reg;
    texel_t      expected_texels[$];
    int unsigned mismatches;
    int unsigned reports_shown;

    function new();
        format_reg    = FMT_BC1;
        mismatches    = 0;
        reports_shown = 0;
    endfunction

    function void set_format(logic [2:0] fmt);
        format_reg = fmt;
    endfunction

    // Round num/den to nearest, ties up
    function int unsigned rounded_div(int unsigned num, int unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function logic [7:0] blend_channel(int unsigned a, int unsigned b, int unsigned wa,
                                       int unsigned wb, int unsigned den,
                                       int unsigned maxv);
        return 8'(rounded_div(255 * (wa * a + wb * b), den * maxv));
    endfunction

    // Decode one texel from a 565 endpoint half with 2-bit indices
    function texel_t color_texel(logic [63:0] half, int unsigned t, bit allow3);
        int unsigned c0, c1, idx, wa, wb, den;
        texel_t      px;
        c0  = half[15:0];
        c1  = half[31:16];
        idx = (half >> (32 + 2 * t)) & 64'd3;
        if (idx == 0) begin
            wa = 1; wb = 0; den = 1;
        end else if (idx == 1) begin
            wa = 0; wb = 1; den = 1;
        end else if (allow3 && c0 <= c1) begin
            // three-color mode: index 3 is transparent black
            if (idx == 3) begin
                px = '0;
                return px;
            end
            wa = 1; wb = 1; den = 2;
        end else if (idx == 2) begin
            wa = 2; wb = 1; den = 3;
        end else begin
            wa = 1; wb = 2; den = 3;
        end
        px.red   = blend_channel((c0 >> 11) & 31, (c1 >> 11) & 31, wa, wb, den, 31);
        px.green = blend_channel((c0 >> 5) & 63, (c1 >> 5) & 63, wa, wb, den, 63);
        px.blue  = blend_channel(c0 & 31, c1 & 31, wa, wb, den, 31);
        px.alpha = 8'd255;
        return px;
    endfunction

    // Decode one value from an 8-bit endpoint half with 3-bit indices
    function logic [7:0] alpha_texel(logic [63:0] half, int unsigned t);
        int unsigned a0, a1, idx;
        a0  = half[7:0];
        a1  = half[15:8];
        idx = (half >> (16 + 3 * t)) & 64'd7;
        if (idx == 0) return 8'(a0);
        if (idx == 1) return 8'(a1);
        if (a0 > a1) return 8'(rounded_div((8 - idx) * a0 + (idx - 1) * a1, 7));
        if (idx == 6) return 8'd0;
        if (idx == 7) return 8'd255;
        return 8'(rounded_div((6 - idx) * a0 + (idx - 1) * a1, 5));
    endfunction

    function texel_t decode_texel(logic [63:0] lo, logic [63:0] hi, logic [1:0] x,
                                  logic [1:0] y);
        int unsigned t;
        texel_t      px;
        t  = {y, x};
        px = '0;
        case (format_reg)
            FMT_BC1: px = color_texel(lo, t, 1'b1);
            FMT_BC2: begin
                px       = color_texel(hi, t, 1'b0);
                px.alpha = 8'(((lo >> (4 * t)) & 64'd15) * 17);
            end
            FMT_BC3: begin
                px       = color_texel(hi, t, 1'b0);
                px.alpha = alpha_texel(lo, t);
            end
            FMT_BC4: begin
                px.red   = alpha_texel(lo, t);
                px.alpha = 8'd255;
            end
            FMT_BC5: begin
                px.red   = alpha_texel(lo, t);
                px.green = alpha_texel(hi, t);
                px.alpha = 8'd255;
            end
            default: px = '0;
        endcase
        return px;
    endfunction

    // Queue the texel an accepted input transaction must produce
    function void note_block(logic [63:0] lo, logic [63:0] hi, logic [1:0] x,
                             logic [1:0] y);
        expected_texels.push_back(decode_texel(lo, hi, x, y));
    endfunction

    // Compare an output transaction with the oldest queued texel
    function void check_texel(texel_t got);
        texel_t exp_px;
        if (expected_texels.size() == 0) begin
            mismatches++;
            if (reports_shown < 10) begin
                reports_shown++;
                $display("ERROR: unexpected texel r=%0d g=%0d b=%0d a=%0d",
                         got.red, got.green, got.blue, got.alpha);
            end
            return;
        end
        exp_px = expected_texels.pop_front();
        if (got.red !== exp_px.red || got.green !== exp_px.green ||
            got.blue !== exp_px.blue || got.alpha !== exp_px.alpha) begin
            mismatches++;
            if (reports_shown < 10) begin
                reports_shown++;
                $display("ERROR: texel mismatch exp r=%0d g=%0d b=%0d a=%0d got r=%0d g=%0d b=%0d a=%0d",
                         exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha,
                         got.red, got.green, got.blue, got.alpha);
            end
        end
    endfunction

    function int unsigned pending();
        return expected_texels.size();
    endfunction

    // Count texels that never arrived
    function void flag_leftovers();
        if (expected_texels.size() != 0) begin
            mismatches += expected_texels.size();
            $display("ERROR: %0d texels never arrived", expected_texels.size());
        end
    endfunction
endclass

module tb_bc_block_texel_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 128;
    localparam int LONG_HOLD   = 80;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data   = '0;
    logic        i_valid      = 1'b0;
    logic        o_ready;
    logic [63:0] i_block_low  = '0;
    logic [63:0] i_block_high = '0;
    logic [1:0]  i_texel_x    = '0;
    logic [1:0]  i_texel_y    = '0;
    logic        o_valid;
    logic        i_ready      = 1'b0;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;

    bit long_hold_req = 1'b0;

    texel_scoreboard sb = new();

    bc_block_texel_decoder uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_block_low  (i_block_low),
        .i_block_high (i_block_high),
        .i_texel_x    (i_texel_x),
        .i_texel_y    (i_texel_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Check every output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_texel({o_red, o_green, o_blue, o_alpha});
        end
    end

    // Stall the output on changing patterns; hold off for a long stretch on request
    initial begin
        int unsigned mode;
        int unsigned run_len;
        int unsigned tick;
        tick = 0;
        forever begin
            if (long_hold_req) begin
                repeat (LONG_HOLD) begin
                    @(posedge i_clk);
                    i_ready <= 1'b0;
                end
                long_hold_req = 1'b0;
            end
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(16, 120);
            repeat (run_len) begin
                @(posedge i_clk);
                tick++;
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 1) == 1);
                    2: i_ready <= (tick % 3 == 0);
                    default: i_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Offer one block and wait for the transaction
    task automatic send_block(logic [63:0] lo, logic [63:0] hi, logic [1:0] x,
                              logic [1:0] y);
        i_valid      <= 1'b1;
        i_block_low  <= lo;
        i_block_high <= hi;
        i_texel_x    <= x;
        i_texel_y    <= y;
        do @(posedge i_clk); while (!o_ready);
        sb.note_block(lo, hi, x, y);
    endtask

    // Write the format register; only called with nothing in flight
    task automatic write_format(logic [2:0] fmt);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= fmt;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_format(fmt);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain every expected texel, then let the pipeline settle
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Random block, biased toward equal endpoints and top indices
    task automatic random_block(output logic [63:0] lo, output logic [63:0] hi);
        int unsigned pick;
        lo   = {$urandom, $urandom};
        hi   = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        case (pick)
            0: begin
                lo[15:8] = lo[7:0];
                hi[15:8] = hi[7:0];
            end
            1: begin
                lo[31:16] = lo[15:0];
                hi[31:16] = hi[15:0];
            end
            2: begin
                lo[63:32] = '1;
                hi[63:16] = '1;
            end
            default: ;
        endcase
    endtask

    // Fixed blocks: all zeros, all ones, three-color blend, four-color spread
    task automatic directed_block(int k, output logic [63:0] lo, output logic [63:0] hi,
                                  output logic [1:0] x, output logic [1:0] y);
        case (k)
            0: begin
                lo = '0; hi = '0; x = 2'd0; y = 2'd0;
            end
            1: begin
                lo = '1; hi = '1; x = 2'd3; y = 2'd3;
            end
            2: begin
                lo = 64'hAAAAAAAA_FFFF_00F0;
                hi = 64'hE4E4E4E4_0000_FFFF;
                x  = 2'd1; y = 2'd2;
            end
            default: begin
                lo = 64'h1B1B1B1B_00F0_F00F;
                hi = 64'hAAAAAAAA_FFFF_0000;
                x  = 2'd2; y = 2'd1;
            end
        endcase
    endtask

    initial begin
        logic [63:0] lo, hi;
        logic [1:0]  x, y;
        logic [2:0]  fmt;
        int unsigned burst_left;
        int unsigned gap;
        bit          no_gaps;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed blocks under every format code
        for (int f = 0; f < 8; f++) begin
            wait_drained();
            write_format(3'(f));
            for (int k = 0; k < 4; k++) begin
                if (f < 5 || k == 1) begin
                    directed_block(k, lo, hi, x, y);
                    send_block(lo, hi, x, y);
                end
            end
            i_valid <= 1'b0;
        end

        // Random phases, one format each
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            fmt = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
            write_format(fmt);
            no_gaps = (p == 2);
            if (no_gaps) long_hold_req = 1'b1;
            burst_left = $urandom_range(1, 12);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_block(lo, hi);
                x = 2'($urandom_range(0, 3));
                y = 2'($urandom_range(0, 3));
                send_block(lo, hi, x, y);
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
                                                             : $urandom_range(1, 12);
                    if (!no_gaps && n < PHASE_ITEMS - 1) begin
                        gap = $urandom_range(1, 8);
                        i_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
            i_valid <= 1'b0;
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        sb.flag_leftovers();
        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
